[hw/rtl/imapd_pkg.sv]
package imapd_pkg;

    // Number of header bytes at the start of each packet.
    localparam int HEADER_BYTES = 4;
    localparam int HDR_POS_W    = $clog2(HEADER_BYTES + 1);

    // Step index limits and nibble fields.
    localparam int              IDX_W    = 7;
    localparam logic [7:0]      IDX_MAX8 = 8'd88;
    localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;
    localparam logic [3:0]      SIGN_BIT = 4'h8;
    localparam logic [3:0]      MAG_MASK = 4'h7;
    localparam logic [7:0]      NIB_MASK = 8'h0F;

    // Saturation limits of the predictor.
    localparam logic signed [17:0] PRED_MAX = 18'sd32767;
    localparam logic signed [17:0] PRED_MIN = -18'sd32768;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Commands passed from the front to the back.
    typedef enum logic [1:0] {
        CMD_SEED_PRED,
        CMD_SEED_INDEX,
        CMD_DECODE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [15:0] data;
    } cmd_t;

    // Standard IMA step sizes.
    localparam logic [14:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Standard IMA index adjustment by code magnitude.
    function automatic logic signed [7:0] index_move(input logic [2:0] mag);
        logic signed [7:0] mv;
        case (mag)
            3'd4:    mv = 8'sd2;
            3'd5:    mv = 8'sd4;
            3'd6:    mv = 8'sd6;
            3'd7:    mv = 8'sd8;
            default: mv = -8'sd1;
        endcase
        return mv;
    endfunction

endpackage

[hw/rtl/imapd_front.sv]
module imapd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        packet_byte,
    input  logic              packet_first,
    input  logic              queue_full,
    output logic              in_stall,
    output logic              push,
    output imapd_pkg::cmd_t   cmd
);
    import imapd_pkg::*;

    localparam logic [HDR_POS_W-1:0] HDR_DONE = HDR_POS_W'(HEADER_BYTES);
    localparam logic [HDR_POS_W-1:0] POS_HI   = HDR_POS_W'(0);
    localparam logic [HDR_POS_W-1:0] POS_LO   = HDR_POS_W'(1);
    localparam logic [HDR_POS_W-1:0] POS_IDX  = HDR_POS_W'(2);

    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic [7:0]           seed_hi_reg, seed_hi_next;
    logic [HDR_POS_W-1:0] pos;
    logic                 in_header;
    logic                 accept;

    // The queue stalls the input when it has no room.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // A flagged byte restarts the header at byte zero.
    assign pos       = packet_first ? POS_HI : hdr_pos_reg;
    assign in_header = (pos < HDR_DONE);

    // Classify the beat and build the command for the back.
    always_comb
    begin
        hdr_pos_next = hdr_pos_reg;
        seed_hi_next = seed_hi_reg;
        push         = 1'b0;
        cmd.kind     = CMD_DECODE;
        cmd.data     = {8'd0, packet_byte};
        if (accept)
        begin
            if (in_header)
            begin
                hdr_pos_next = pos + POS_LO;
                if (pos == POS_HI)
                begin
                    seed_hi_next = packet_byte;
                end
                else if (pos == POS_LO)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_SEED_PRED;
                    cmd.data = {seed_hi_reg, packet_byte};
                end
                else if (pos == POS_IDX)
                begin
                    push     = 1'b1;
                    cmd.kind = CMD_SEED_INDEX;
                    cmd.data = (packet_byte > IDX_MAX8) ? {8'd0, IDX_MAX8}
                                                        : {8'd0, packet_byte};
                end
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    // Header position and the saved high seed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg <= HDR_DONE;
            seed_hi_reg <= 8'd0;
        end
        else
        begin
            hdr_pos_reg <= hdr_pos_next;
            seed_hi_reg <= seed_hi_next;
        end
    end

endmodule

[hw/rtl/imapd_cmd_queue.sv]
module imapd_cmd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  imapd_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output imapd_pkg::cmd_t   head_cmd
);
    import imapd_pkg::*;

    localparam logic [QCNT_W-1:0] DEPTH_C = QCNT_W'(QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] LAST_C  = QPTR_W'(QUEUE_DEPTH - 1);

    cmd_t              entry_reg [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == DEPTH_C);
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/imapd_back.sv]
module imapd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  imapd_pkg::cmd_t   head_cmd,
    output logic              pop,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [15:0]       sample,
    output logic              last_of_byte
);
    import imapd_pkg::*;

    logic signed [15:0] pred_reg, pred_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        sample_reg;
    logic               last_reg;

    logic               adv;
    logic               fire;
    logic               seed;
    logic [3:0]         nib;
    logic [14:0]        step;
    logic [17:0]        prod;
    logic [16:0]        delta;
    logic signed [17:0] p_wide;
    logic signed [15:0] p_sat;
    logic signed [7:0]  idx_sum;
    logic [IDX_W-1:0]   idx_new;

    // The output register frees up when it is empty or being taken.
    assign adv  = !out_valid_reg || !out_stall;
    assign seed = !empty && (head_cmd.kind != CMD_DECODE);
    assign fire = !empty && (head_cmd.kind == CMD_DECODE) && adv;
    assign pop  = seed || (fire && phase_reg);

    // High nibble in the first pass, low nibble in the second.
    assign nib = phase_reg ? 4'(head_cmd.data[7:0] & NIB_MASK) : head_cmd.data[7:4];

    // One nibble decode: step lookup, scaled delta, saturating update.
    always_comb
    begin
        step    = STEP_TABLE[idx_reg];
        prod    = {3'd0, step} * {15'd0, nib[2:0] & MAG_MASK[2:0]};
        delta   = {1'b0, prod[17:2]} + {5'd0, step[14:3]};
        if ((nib & SIGN_BIT) != 4'h0)
        begin
            p_wide = 18'(pred_reg) - signed'({1'b0, delta});
        end
        else
        begin
            p_wide = 18'(pred_reg) + signed'({1'b0, delta});
        end
        if (p_wide > PRED_MAX)
        begin
            p_sat = 16'sh7FFF;
        end
        else if (p_wide < PRED_MIN)
        begin
            p_sat = -16'sh8000;
        end
        else
        begin
            p_sat = p_wide[15:0];
        end
        idx_sum = signed'({1'b0, idx_reg}) + index_move(nib[2:0]);
        if (idx_sum < 8'sd0)
        begin
            idx_new = '0;
        end
        else if (idx_sum > signed'({1'b0, IDX_MAX}))
        begin
            idx_new = IDX_MAX;
        end
        else
        begin
            idx_new = idx_sum[IDX_W-1:0];
        end
    end

    // Decoder state: seeds load directly, decodes step the state.
    always_comb
    begin
        pred_next      = pred_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (seed)
        begin
            case (head_cmd.kind)
                CMD_SEED_PRED:  pred_next = head_cmd.data;
                CMD_SEED_INDEX: idx_next  = head_cmd.data[IDX_W-1:0];
                default:        pred_next = pred_reg;
            endcase
        end
        else if (fire)
        begin
            pred_next      = p_sat;
            idx_next       = idx_new;
            phase_next     = !phase_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg      <= '0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pred_reg      <= pred_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register, loaded with each decoded sample.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            sample_reg <= p_sat;
            last_reg   <= phase_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign last_of_byte = last_reg;

endmodule

[hw/rtl/ima_adpcm_packet_decoder.sv]
// With the queue and output empty, a coded byte accepted at the input is written to a
// queue entry; its high-nibble sample and then its low-nibble sample follow at the output.
// Throughput: one sample per cycle unless the output stalls, set by the single nibble
// decode unit in the back; header bytes go in at one per cycle while the queue has room.
// A four-entry command queue lets the input run ahead while the output is stalled.
// Reset: asynchronous and active low; predictor and step index clear to zero, the
// header position reads as past the header, and the queue and output are emptied.
module ima_adpcm_packet_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         packet_byte,
    input  logic               packet_first,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    output logic               last_of_byte
);
    import imapd_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    cmd_t  push_cmd;
    cmd_t  head_cmd;
    logic [15:0] sample_bits;

    // Front: header tracking and command classification.
    imapd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .packet_byte  (packet_byte),
        .packet_first (packet_first),
        .queue_full   (full),
        .in_stall     (in_stall),
        .push         (push),
        .cmd          (push_cmd)
    );

    // Queue between the two halves.
    imapd_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head_cmd (head_cmd)
    );

    // Back: nibble decoding and the output register.
    imapd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .sample       (sample_bits),
        .last_of_byte (last_of_byte)
    );

    assign sample = signed'(sample_bits);

endmodule

[hw/rtl/imapd_checker.sv]
module imapd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         packet_byte,
    input  logic               packet_first,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] sample,
    input  logic               last_of_byte
);

    logic expect_last_reg;

    // Samples come in pairs, so the expected position toggles on every output beat that is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_last_reg <= 1'b0;
        end
        else if (out_valid && !out_stall)
        begin
            expect_last_reg <= !expect_last_reg;
        end
    end

    // A stalled input beat stays offered and unchanged.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(packet_byte) && $stable(packet_first))
        else $error("input beat changed while stalled");

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last_of_byte))
        else $error("output beat changed while stalled");

    // High and low nibble samples alternate strictly.
    a_pairing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> last_of_byte == expect_last_reg)
        else $error("sample pairing broken");

    // Once the high sample is taken, the low sample of the same byte follows at once.
    a_low_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_byte |=> out_valid && last_of_byte)
        else $error("low nibble sample did not follow");

endmodule

bind ima_adpcm_packet_decoder imapd_checker u_imapd_checker (.*);

[dv/tb_ima_adpcm_packet_decoder.sv]
`timescale 1ns / 1ps

module tb_ima_adpcm_packet_decoder;

    import imapd_pkg::*;

    localparam int RANDOM_BEATS   = 1150;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_BEAT   = 800;
    localparam int CALM_FROM      = 300;
    localparam int CALM_TO        = 500;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [7:0] data;
        logic       first;
    } beat_t;

    typedef struct {
        logic signed [15:0] value;
        logic               second;
    } sample_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [7:0]         packet_byte  = 8'h00;
    logic               packet_first = 1'b0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic signed [15:0] sample;
    logic               last_of_byte;

    beat_t   pending_beats[$];
    sample_t expected_samples[$];
    sample_t want_sample;

    // Decoder state kept by the testbench.
    int         pred_level;
    int         step_idx;
    int         hdr_count;
    logic [7:0] seed_msb;

    int  total_beats;
    int  bytes_taken;
    int  mismatches;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_done;
    bit  stuck;

    ima_adpcm_packet_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packet_byte  (packet_byte),
        .packet_first (packet_first),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample       (sample),
        .last_of_byte (last_of_byte)
    );

    always #6 clk = ~clk;

    task automatic note_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Decodes one 4-bit code and advances the predictor and step index.
    function automatic logic signed [15:0] decode_code(input logic [3:0] code);
        int step;
        int mag;
        int delta;
        int level;
        step  = STEP_TABLE[step_idx];
        mag   = int'(code & MAG_MASK);
        delta = ((step * mag) >> 2) + (step >> 3);
        level = ((code & SIGN_BIT) != 0) ? pred_level - delta : pred_level + delta;
        if (level > 32767)
            level = 32767;
        if (level < -32768)
            level = -32768;
        pred_level = level;
        step_idx += (mag < 4) ? -1 : 2 * (mag - 3);
        if (step_idx < 0)
            step_idx = 0;
        if (step_idx > int'(IDX_MAX))
            step_idx = int'(IDX_MAX);
        return 16'(level);
    endfunction

    // Works out the samples that one accepted byte causes, if any.
    task automatic predict_samples(input logic [7:0] b, input logic first);
        sample_t s;
        if (first)
            hdr_count = 0;
        if (hdr_count < HEADER_BYTES)
        begin
            case (hdr_count)
                0: seed_msb = b;
                1: pred_level = int'($signed({seed_msb, b}));
                2: step_idx = (b > IDX_MAX) ? int'(IDX_MAX) : int'(b);
                default: ;
            endcase
            hdr_count++;
        end
        else
        begin
            s.value  = decode_code(b[7:4]);
            s.second = 1'b0;
            expected_samples.push_back(s);
            s.value  = decode_code(b[3:0]);
            s.second = 1'b1;
            expected_samples.push_back(s);
        end
    endtask

    task automatic add_beat(input logic [7:0] b, input logic first);
        beat_t bt;
        bt.data  = b;
        bt.first = first;
        pending_beats.push_back(bt);
    endtask

    // Random idling on both sides, switched off for one stretch of the run.
    function automatic bit idle_roll();
        if (bytes_taken >= CALM_FROM && bytes_taken < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < 27;
    endfunction

    // Sender: offers queued beats and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            packet_byte  <= 8'h00;
            packet_first <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_samples(packet_byte, packet_first);
                bytes_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() > 0 && !idle_roll())
                begin
                    in_valid     <= 1'b1;
                    packet_byte  <= pending_beats[0].data;
                    packet_first <= pending_beats[0].first;
                    void'(pending_beats.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted sample and drives the stall, with one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    note_mismatch($sformatf("sample %0d with none expected", sample));
                end
                else
                begin
                    want_sample = expected_samples.pop_front();
                    if (sample !== want_sample.value)
                        note_mismatch($sformatf("sample %0d, expected %0d",
                                                sample, want_sample.value));
                    if (last_of_byte !== want_sample.second)
                        note_mismatch($sformatf("last_of_byte %b, expected %b",
                                                last_of_byte, want_sample.second));
                end
            end
            if (!hold_done && bytes_taken >= HOLD_AT_BEAT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= idle_roll();
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
            stuck = 1'b1;
    end

    initial
    begin
        int         kind;
        int         n;
        bit         burst;
        logic       sgn;
        logic [15:0] seed_word;
        logic [7:0] idx_byte;

        pred_level = 0;
        step_idx   = 0;
        hdr_count  = HEADER_BYTES;
        seed_msb   = 8'h00;

        // Coded bytes before any packet start use the reset state.
        add_beat(8'h07, 1'b0);
        add_beat(8'h80, 1'b0);
        // Largest positive seed with an out-of-range index: drives the upper clamp.
        add_beat(8'h7F, 1'b1);
        add_beat(8'hFF, 1'b0);
        add_beat(8'd200, 1'b0);
        add_beat(8'hAA, 1'b0);
        add_beat(8'h77, 1'b0);
        add_beat(8'h70, 1'b0);
        // Most negative seed with the top index: drives the lower clamp.
        add_beat(8'h80, 1'b1);
        add_beat(8'h00, 1'b0);
        add_beat(8'd88, 1'b0);
        add_beat(8'h55, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h88, 1'b0);
        // A packet cut short in its header, then a fresh packet at index zero.
        add_beat(8'h12, 1'b1);
        add_beat(8'h34, 1'b0);
        add_beat(8'h05, 1'b0);
        add_beat(8'h00, 1'b1);
        add_beat(8'h00, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'hFF, 1'b0);
        add_beat(8'h19, 1'b0);

        // Random packets: mostly well formed, some truncated, some noise.
        total_beats = pending_beats.size() + RANDOM_BEATS;
        while (pending_beats.size() < total_beats)
        begin
            kind = $urandom_range(99);
            if (kind < 85)
            begin
                if ($urandom_range(9) == 0)
                    seed_word = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                else
                    seed_word = 16'($urandom);
                idx_byte = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(88));
                add_beat(seed_word[15:8], 1'b1);
                add_beat(seed_word[7:0], 1'b0);
                add_beat(idx_byte, 1'b0);
                add_beat(8'($urandom), 1'b0);
                burst = ($urandom_range(5) == 0);
                sgn   = 1'($urandom_range(1));
                n     = $urandom_range(12, 1);
                repeat (n)
                begin
                    if (burst)
                        add_beat({sgn, 3'($urandom), sgn, 3'($urandom)}, 1'b0);
                    else
                        add_beat(8'($urandom), 1'b0);
                end
            end
            else if (kind < 95)
            begin
                n = $urandom_range(3, 1);
                add_beat(8'($urandom), 1'b1);
                repeat (n - 1)
                    add_beat(8'($urandom), 1'b0);
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                    add_beat(8'($urandom), $urandom_range(7) == 0);
            end
        end
        total_beats = pending_beats.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (!stuck && bytes_taken < total_beats)
            @(posedge clk);
        while (!stuck && expected_samples.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (expected_samples.size() > 0)
            note_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
        if (!stuck && mismatches == 0)
            $display("tb_ima_adpcm_packet_decoder OK");
        else
            $display("tb_ima_adpcm_packet_decoder NOT OK");
        $finish;
    end

endmodule

[files.f]
hw/rtl/imapd_pkg.sv
hw/rtl/imapd_front.sv
hw/rtl/imapd_cmd_queue.sv
hw/rtl/imapd_back.sv
hw/rtl/ima_adpcm_packet_decoder.sv
hw/rtl/imapd_checker.sv
dv/tb_ima_adpcm_packet_decoder.sv
